@@ design/lfa_pkg.sv @@
package lfa_pkg;

   localparam int COUNT_WIDTH     = 32;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 16;

   // operation codes
   localparam logic [2:0] OP_PRIMARY_CMD   = 3'd0;
   localparam logic [2:0] OP_BACKUP_CMD    = 3'd1;
   localparam logic [2:0] OP_PRIMARY_READY = 3'd2;
   localparam logic [2:0] OP_PRIMARY_RECV  = 3'd3;
   localparam logic [2:0] OP_PRIMARY_SEND  = 3'd4;
   localparam logic [2:0] OP_TICK          = 3'd5;

   // link status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_NO_DATA    = 2'd1;
   localparam logic [1:0] STATUS_SEND_RETRY = 2'd2;

   // event codes
   localparam logic [2:0] EV_NONE         = 3'd0;
   localparam logic [2:0] EV_REJECTED     = 3'd1;
   localparam logic [2:0] EV_CONNECTED    = 3'd2;
   localparam logic [2:0] EV_DISCONNECTED = 3'd3;
   localparam logic [2:0] EV_TO_PRIMARY   = 3'd4;
   localparam logic [2:0] EV_TO_BACKUP    = 3'd5;

   // authority values
   localparam logic AUTH_PRIMARY = 1'b0;
   localparam logic AUTH_BACKUP  = 1'b1;

   // configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FALLBACK_TICKS    = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RECONNECT_SECONDS = 1'd1;

   localparam logic [15:0] FALLBACK_TICKS_RESET    = 16'd5;
   localparam logic [7:0]  RECONNECT_SECONDS_RESET = 8'd1;

   // counter slots: {reject, link}
   localparam logic [1:0] CNT_PRIMARY_ACCEPT = 2'd0;
   localparam logic [1:0] CNT_BACKUP_ACCEPT  = 2'd1;
   localparam logic [1:0] CNT_PRIMARY_REJECT = 2'd2;
   localparam logic [1:0] CNT_BACKUP_REJECT  = 2'd3;

   typedef struct packed {
      logic [2:0]  operation;
      logic [1:0]  link_status;
      logic [31:0] now_seconds;
      logic [19:0] now_micros;
      logic [15:0] now_base;
   } req_type;

   typedef struct packed {
      logic                   accepted;
      logic                   authority;
      logic                   link_up;
      logic [15:0]            down_ticks;
      logic [2:0]             event_code;
      logic [COUNT_WIDTH-1:0] primary_accepts;
      logic [COUNT_WIDTH-1:0] backup_accepts;
      logic [COUNT_WIDTH-1:0] primary_rejects;
      logic [COUNT_WIDTH-1:0] backup_rejects;
   } rsp_type;

   typedef struct packed {
      logic                        authority;
      logic                        connected;
      logic [15:0]                 down_ticks;
      logic [31:0]                 since_seconds;
      logic [19:0]                 since_micros;
      logic [15:0]                 since_base;
      logic                        since_valid;
      logic [3:0][COUNT_WIDTH-1:0] counts;
   } state_type;

   typedef struct packed {
      logic [15:0] fallback_ticks;
      logic [7:0]  reconnect_seconds;
   } cfg_type;

endpackage

@@ design/link_failover_authority_unit.sv @@
// Command authority arbiter for a primary and a backup command link. Each
// request transaction is one event (command, link ready, receive or send
// status, or scheduler tick) with the current time, and yields exactly one
// response transaction carrying the accept bit, the authority and link
// state after the event, and the four wrapping accept and reject counters.
// An event is evaluated in the cycle it is accepted and its response sits in
// the output register on the next cycle; a new request is taken every cycle
// as long as the response register is empty or being drained, so the block
// sustains one event per clock. The two configuration registers are written
// through the csr_ port and should only change while no transaction is in
// flight.
module link_failover_authority_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  lfa_pkg::req_type                      req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output lfa_pkg::rsp_type                      rsp_payload,
   input  logic                                  csr_write,
   input  logic [lfa_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [lfa_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);
   import lfa_pkg::*;

   state_type state_ff;
   state_type state_in;
   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   rsp_type   step_result;
   logic      can_load;
   logic      take;

   assign req_ready = can_load;
   assign take      = req_valid && can_load;

   lfa_step u_step (
      .item   (req_payload),
      .cur    (state_ff),
      .cfg    (cfg_ff),
      .nxt    (state_in),
      .result (step_result)
   );

   lfa_rsp_reg u_rsp (
      .clock       (clock),
      .reset       (reset),
      .load        (take),
      .load_data   (step_result),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .can_load    (can_load)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_FALLBACK_TICKS:    cfg_in.fallback_ticks    = csr_wdata;
            REG_RECONNECT_SECONDS: cfg_in.reconnect_seconds = csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fallback_ticks    <= FALLBACK_TICKS_RESET;
         cfg_ff.reconnect_seconds <= RECONNECT_SECONDS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (take) begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/lfa_step.sv @@
module lfa_step (
   input  lfa_pkg::req_type   item,
   input  lfa_pkg::state_type cur,
   input  lfa_pkg::cfg_type   cfg,
   output lfa_pkg::state_type nxt,
   output lfa_pkg::rsp_type   result
);
   import lfa_pkg::*;

   logic        link_req;
   logic        link_target;
   logic        cmd_link;
   logic        accepted;
   logic [2:0]  event_code;
   logic        earlier;
   logic [31:0] elapsed;
   logic [1:0]  slot;

   always_comb begin
      nxt         = cur;
      accepted    = 1'b0;
      event_code  = EV_NONE;
      link_req    = 1'b0;
      link_target = 1'b0;
      cmd_link    = item.operation[0];
      slot        = CNT_PRIMARY_ACCEPT;
      earlier     = (item.now_seconds < cur.since_seconds) ||
                    ((item.now_seconds == cur.since_seconds) &&
                     (item.now_micros < cur.since_micros));
      elapsed     = item.now_seconds - cur.since_seconds -
                    {31'd0, (item.now_micros < cur.since_micros)};

      case (item.operation)
         OP_PRIMARY_CMD, OP_BACKUP_CMD: begin
            if (cur.authority == cmd_link) begin
               accepted = 1'b1;
               slot     = cmd_link ? CNT_BACKUP_ACCEPT : CNT_PRIMARY_ACCEPT;
            end else begin
               event_code = EV_REJECTED;
               slot       = cmd_link ? CNT_BACKUP_REJECT : CNT_PRIMARY_REJECT;
            end
            nxt.counts[slot] = cur.counts[slot] + COUNT_WIDTH'(1);
         end
         OP_PRIMARY_READY: begin
            link_req    = 1'b1;
            link_target = 1'b1;
         end
         OP_PRIMARY_RECV: begin
            link_req = !(item.link_status inside {STATUS_OK, STATUS_NO_DATA});
         end
         OP_PRIMARY_SEND: begin
            link_req = !(item.link_status inside {STATUS_OK, STATUS_SEND_RETRY});
         end
         OP_TICK: begin
            if (cur.connected) begin
               nxt.down_ticks = 16'd0;
               if (cur.authority == AUTH_BACKUP) begin
                  if (!cur.since_valid || (item.now_base != cur.since_base) || earlier) begin
                     // re-base the connect time and wait again
                     nxt.since_seconds = item.now_seconds;
                     nxt.since_micros  = item.now_micros;
                     nxt.since_base    = item.now_base;
                     nxt.since_valid   = 1'b1;
                  end else if (elapsed >= {24'd0, cfg.reconnect_seconds}) begin
                     nxt.authority = AUTH_PRIMARY;
                     event_code    = EV_TO_PRIMARY;
                  end
               end
            end else begin
               if (cur.down_ticks < cfg.fallback_ticks) begin
                  nxt.down_ticks = cur.down_ticks + 16'd1;
               end
               if ((cur.authority == AUTH_PRIMARY) &&
                   (nxt.down_ticks >= cfg.fallback_ticks)) begin
                  nxt.authority = AUTH_BACKUP;
                  event_code    = EV_TO_BACKUP;
               end
            end
         end
         default: begin
         end
      endcase

      // apply a connection change only when the flag really flips
      if (link_req && (link_target != cur.connected)) begin
         nxt.connected  = link_target;
         nxt.down_ticks = 16'd0;
         if (link_target) begin
            nxt.since_seconds = item.now_seconds;
            nxt.since_micros  = item.now_micros;
            nxt.since_base    = item.now_base;
            nxt.since_valid   = 1'b1;
            event_code        = EV_CONNECTED;
         end else begin
            nxt.since_valid = 1'b0;
            event_code      = EV_DISCONNECTED;
         end
      end
   end

   always_comb begin
      result.accepted        = accepted;
      result.authority       = nxt.authority;
      result.link_up         = nxt.connected;
      result.down_ticks      = nxt.down_ticks;
      result.event_code      = event_code;
      result.primary_accepts = nxt.counts[CNT_PRIMARY_ACCEPT];
      result.backup_accepts  = nxt.counts[CNT_BACKUP_ACCEPT];
      result.primary_rejects = nxt.counts[CNT_PRIMARY_REJECT];
      result.backup_rejects  = nxt.counts[CNT_BACKUP_REJECT];
   end

endmodule

@@ design/lfa_rsp_reg.sv @@
module lfa_rsp_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  lfa_pkg::rsp_type load_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lfa_pkg::rsp_type rsp_payload,
   output logic             can_load
);
   import lfa_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // take a new transaction when empty or when the held one leaves this cycle
   assign can_load = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule
